>>> rtl/ged_pkg.sv
// ----------------------------------------------------------------------------
// ged_pkg: shared types, constants and functions
// Register indexes, size limits, gray conversion and the 3x3 gradient kernel
// for the gradient edge detector.
// ----------------------------------------------------------------------------
package ged_pkg;

	localparam int GED_MAX_WIDTH  = 1024;
	localparam int GED_MAX_HEIGHT = 4096;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_WID_W  = 11;
	localparam int CFG_HGT_W  = 13;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OPERATOR_KIND = 2'd2;

	localparam logic [CFG_WID_W-1:0] WIDTH_RESET  = 11'd640;
	localparam logic [CFG_HGT_W-1:0] HEIGHT_RESET = 13'd480;

	localparam logic OP_SOBEL   = 1'b0;
	localparam logic OP_PREWITT = 1'b1;

	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = 3;
	localparam int FIFO_CW    = 4;

	typedef enum logic [1:0] {
		MODE_WRAP,
		MODE_GRAD,
		MODE_CENTER
	} mode_t;

	typedef logic [8:0][7:0] gwin_t;

	function automatic logic [31:0] ged_clamp(input logic [31:0] v, input logic [31:0] hi);
		logic [31:0] res;
		if (v < 32'd3) begin
			res = 32'd3;
		end else if (v > hi) begin
			res = hi;
		end else begin
			res = v;
		end
		return res;
	endfunction

	function automatic logic [7:0] ged_gray(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b);
		logic [15:0] s;
		s = 16'(r) * 16'd51 + 16'(g) * 16'd182 + 16'(b) * 16'd18;
		return s[15:8];
	endfunction

	function automatic logic signed [11:0] ged_ext(input logic [7:0] v);
		return $signed({4'b0000, v});
	endfunction

	function automatic logic [7:0] ged_gradient(input gwin_t win, input logic kind);
		logic signed [11:0] dx_mid;
		logic signed [11:0] dy_mid;
		logic signed [11:0] gx;
		logic signed [11:0] gy;
		logic [11:0] ax;
		logic [11:0] ay;
		logic [11:0] sum;
		dx_mid = ged_ext(win[5]) - ged_ext(win[3]);
		dy_mid = ged_ext(win[1]) - ged_ext(win[7]);
		if (kind == OP_SOBEL) begin
			dx_mid = dx_mid <<< 1;
			dy_mid = dy_mid <<< 1;
		end
		gx = ged_ext(win[2]) + ged_ext(win[8]) - ged_ext(win[0]) - ged_ext(win[6]) + dx_mid;
		gy = ged_ext(win[0]) + ged_ext(win[2]) - ged_ext(win[6]) - ged_ext(win[8]) + dy_mid;
		ax = (gx < 0) ? 12'(-gx) : 12'(gx);
		ay = (gy < 0) ? 12'(-gy) : 12'(gy);
		sum = ax + ay;
		return (sum > 12'd255) ? 8'd255 : sum[7:0];
	endfunction

endpackage

>>> rtl/ged_if.sv
// ----------------------------------------------------------------------------
// ged_if: stream channels of the edge detector
// RGB pixel channel and tagged edge result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ged_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source(output valid, output red, output green, output blue, input ready);
	modport sink(input valid, input red, input green, input blue, output ready);
endinterface

interface ged_edge_if #(
	parameter int XW = 10,
	parameter int YW = 12
);
	logic          valid;
	logic          ready;
	logic [XW-1:0] pixel_x;
	logic [YW-1:0] pixel_y;
	logic [7:0]    magnitude;
	logic          last_of_run;

	modport source(output valid, output pixel_x, output pixel_y, output magnitude,
		output last_of_run, input ready);
	modport sink(input valid, input pixel_x, input pixel_y, input magnitude,
		input last_of_run, output ready);
endinterface

>>> rtl/gradient_edge_detector_3x3.sv
// ----------------------------------------------------------------------------
// gradient_edge_detector_3x3: streaming 3x3 Sobel/Prewitt edge detector
// Converts RGB raster pixels to gray and gives |Gx|+|Gy| per interior pixel.
// ----------------------------------------------------------------------------
// pix_in takes one RGB beat per cycle in raster order while ready is high;
// edge_out gives one beat per image pixel, tagged with its column and row,
// the last beat caused by an input pixel marked by last_of_run. Interior
// pixels carry the saturated gradient sum, border pixels their gray value.
// The result for pixel (x, y) is caused by input pixel (x+1, y+1), or for
// the last column by the next input; the last row also comes out as it
// arrives, so those inputs cause two beats. Row 0 inputs cause none.
// An accepted beat passes the read and result stages into the output queue.
// One pixel per cycle is sustained while edge_out does not stall; last-row
// inputs, two beats each, are bound by the single output port. The line
// buffers are two single-write memories read as a pixel is accepted.
// Reset clears the counters, window, queue and loads width 640, height 480,
// Sobel. Configuration is written through cfg_we/cfg_index/cfg_data; the
// user must do so only while the block is idle; the block does not check.
// When edge_out stalls, an 8-beat queue fills; pix_in.ready drops once the
// queue cannot take two results each for the pixels in flight and a new one.
// ----------------------------------------------------------------------------
module gradient_edge_detector_3x3 #(
	parameter int MAX_WIDTH  = ged_pkg::GED_MAX_WIDTH,
	parameter int MAX_HEIGHT = ged_pkg::GED_MAX_HEIGHT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ged_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ged_pkg::CFG_DATA_W-1:0] cfg_data,
	ged_pix_if.sink                        pix_in,
	ged_edge_if.source                     edge_out
);

	import ged_pkg::*;

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);

	typedef struct packed {
		logic [XW-1:0] x;
		logic [YW-1:0] y;
		logic [7:0]    mag;
		logic          last;
	} res_t;

	logic [CFG_WID_W-1:0] width_q;
	logic [CFG_HGT_W-1:0] height_q;
	logic                 kind_q;

	logic [XW-1:0] col_q;
	logic [YW-1:0] row_q;

	logic [WW-1:0] w;
	logic [HW-1:0] h;
	logic          col_ge;
	logic [YW:0]   row_a;
	logic [XW-1:0] c;
	logic [YW-1:0] r;
	logic [XW:0]   c_inc;
	logic [YW:0]   r_inc;
	logic [XW-1:0] wrap_addr;
	logic          accept;
	logic          in_ready;
	mode_t         mode;

	logic          v_s1;
	mode_t         mode_s1;
	logic          first_s1;
	logic          second_s1;
	logic [XW-1:0] x1_s1;
	logic [YW-1:0] y1_s1;
	logic [XW-1:0] c_s1;
	logic [YW-1:0] r_s1;
	logic [7:0]    gray_s1;

	logic          v_s2;
	mode_t         mode_s2;
	logic          first_s2;
	logic          second_s2;
	logic [XW-1:0] x1_s2;
	logic [YW-1:0] y1_s2;
	logic [XW-1:0] c_s2;
	logic [YW-1:0] r_s2;
	logic [7:0]    gray_s2;
	logic [7:0]    wrap_s2;

	logic [7:0] above;
	logic [7:0] two_above;
	logic [7:0] wrap_above;
	gwin_t      win_q;

	res_t               fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wptr_q;
	logic [FIFO_AW-1:0] rptr_q;
	logic [FIFO_CW-1:0] cnt_q;
	logic [7:0]         mag1;
	res_t               res1;
	res_t               res2;
	res_t               slot0;
	logic [1:0]         push_n;
	logic               pop;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			kind_q   <= OP_SOBEL;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:   width_q  <= cfg_data[CFG_WID_W-1:0];
				REG_IMAGE_HEIGHT:  height_q <= cfg_data[CFG_HGT_W-1:0];
				REG_OPERATOR_KIND: kind_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// position of the incoming pixel
	always_comb begin
		w         = WW'(ged_clamp(32'(width_q), 32'(MAX_WIDTH)));
		h         = HW'(ged_clamp(32'(height_q), 32'(MAX_HEIGHT)));
		col_ge    = 32'(col_q) >= 32'(w);
		row_a     = col_ge ? (YW + 1)'(row_q) + 1'b1 : (YW + 1)'(row_q);
		c         = col_ge ? '0 : col_q;
		r         = (32'(row_a) >= 32'(h)) ? '0 : row_a[YW-1:0];
		c_inc     = (XW + 1)'(c) + 1'b1;
		r_inc     = (YW + 1)'(r) + 1'b1;
		wrap_addr = XW'(w - 1'b1);
		priority if (c == '0) begin
			mode = MODE_WRAP;
		end else if (c >= XW'(2) && r >= YW'(2)) begin
			mode = MODE_GRAD;
		end else begin
			mode = MODE_CENTER;
		end
	end

	assign in_ready     = (5'(cnt_q) + {3'b000, v_s1, 1'b0} + {3'b000, v_s2, 1'b0})
		<= 5'(FIFO_DEPTH - 2);
	assign pix_in.ready = in_ready;
	assign accept       = pix_in.valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (32'(c_inc) >= 32'(w)) begin
				col_q <= '0;
				row_q <= (32'(r_inc) >= 32'(h)) ? '0 : r_inc[YW-1:0];
			end else begin
				col_q <= c_inc[XW-1:0];
				row_q <= r;
			end
		end
	end

	// stage 1: memory read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1   <= mode;
			first_s1  <= r != '0;
			second_s1 <= 32'(r) == 32'(h) - 32'd1;
			x1_s1     <= (c == '0) ? wrap_addr : c - 1'b1;
			y1_s1     <= r - 1'b1;
			c_s1      <= c;
			r_s1      <= r;
			gray_s1   <= ged_gray(pix_in.red, pix_in.green, pix_in.blue);
		end
	end

	ged_line_buf #(
		.DEPTH(MAX_WIDTH),
		.AW   (XW)
	) u_line_buf (
		.clk         (clk),
		.rd_en       (accept),
		.rd_addr     (c),
		.rd_wrap_addr(wrap_addr),
		.wr_en       (v_s1),
		.wr_addr     (c_s1),
		.wr_gray     (gray_s1),
		.above       (above),
		.two_above   (two_above),
		.wrap_above  (wrap_above)
	);

	// window shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (v_s1) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= two_above;
			win_q[3] <= win_q[4];
			win_q[4] <= win_q[5];
			win_q[5] <= above;
			win_q[6] <= win_q[7];
			win_q[7] <= win_q[8];
			win_q[8] <= gray_s1;
		end
	end

	// stage 2: result formation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			mode_s2   <= mode_s1;
			first_s2  <= first_s1;
			second_s2 <= second_s1;
			x1_s2     <= x1_s1;
			y1_s2     <= y1_s1;
			c_s2      <= c_s1;
			r_s2      <= r_s1;
			gray_s2   <= gray_s1;
			wrap_s2   <= wrap_above;
		end
	end

	always_comb begin
		unique case (mode_s2)
			MODE_WRAP:   mag1 = wrap_s2;
			MODE_GRAD:   mag1 = ged_gradient(win_q, kind_q);
			MODE_CENTER: mag1 = win_q[4];
			default:     mag1 = win_q[4];
		endcase
		res1   = '{x: x1_s2, y: y1_s2, mag: mag1, last: !second_s2};
		res2   = '{x: c_s2, y: r_s2, mag: gray_s2, last: 1'b1};
		slot0  = first_s2 ? res1 : res2;
		push_n = v_s2 ? 2'(first_s2) + 2'(second_s2) : 2'd0;
	end

	// output queue
	assign pop = edge_out.valid && edge_out.ready;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			fifo_q[wptr_q] <= slot0;
		end
		if (push_n == 2'd2) begin
			fifo_q[wptr_q + 1'b1] <= res2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			wptr_q <= wptr_q + FIFO_AW'(push_n);
			rptr_q <= rptr_q + FIFO_AW'(pop);
			cnt_q  <= cnt_q + FIFO_CW'(push_n) - FIFO_CW'(pop);
		end
	end

	assign edge_out.valid       = cnt_q != '0;
	assign edge_out.pixel_x     = fifo_q[rptr_q].x;
	assign edge_out.pixel_y     = fifo_q[rptr_q].y;
	assign edge_out.magnitude   = fifo_q[rptr_q].mag;
	assign edge_out.last_of_run = fifo_q[rptr_q].last;

endmodule

>>> rtl/ged_line_buf.sv
// ----------------------------------------------------------------------------
// ged_line_buf: two gray line buffers
// Synchronous-read memories for the previous two rows, with
// forwarding of the write issued in the same cycle as a read.
// ----------------------------------------------------------------------------
module ged_line_buf #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	input  logic [AW-1:0] rd_wrap_addr,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_gray,
	output logic [7:0]    above,
	output logic [7:0]    two_above,
	output logic [7:0]    wrap_above
);

	logic [7:0] above_mem [DEPTH];
	logic [7:0] two_above_mem [DEPTH];

	logic [7:0] above_rd_q;
	logic [7:0] two_above_rd_q;
	logic [7:0] wrap_rd_q;
	logic       fwd_hit_q;
	logic       fwd_wrap_q;
	logic [7:0] fwd_gray_q;
	logic [7:0] fwd_above_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			above_mem[wr_addr]     <= wr_gray;
			two_above_mem[wr_addr] <= above;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			above_rd_q     <= above_mem[rd_addr];
			two_above_rd_q <= two_above_mem[rd_addr];
			wrap_rd_q      <= above_mem[rd_wrap_addr];
			fwd_hit_q      <= wr_en && (wr_addr == rd_addr);
			fwd_wrap_q     <= wr_en && (wr_addr == rd_wrap_addr);
			fwd_gray_q     <= wr_gray;
			fwd_above_q    <= above;
		end
	end

	assign above      = fwd_hit_q  ? fwd_gray_q  : above_rd_q;
	assign two_above  = fwd_hit_q  ? fwd_above_q : two_above_rd_q;
	assign wrap_above = fwd_wrap_q ? fwd_gray_q  : wrap_rd_q;

endmodule

>>> rtl/ged_checker.sv
// ----------------------------------------------------------------------------
// ged_checker: port-level checks of the edge detector
// Watches the result channel of the top level over time.
// ----------------------------------------------------------------------------
module ged_checker #(
	parameter int XW = 10,
	parameter int YW = 12
) (
	input logic          clk,
	input logic          arst_n,
	input logic          out_valid,
	input logic          out_ready,
	input logic [XW-1:0] out_x,
	input logic [YW-1:0] out_y,
	input logic [7:0]    out_mag,
	input logic          out_last
);

	a_no_beat_in_reset: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result beat during reset");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_x) && $stable(out_y) && $stable(out_mag)
		&& $stable(out_last))
		else $error("result beat changed while stalled");

	// a beat followed by another of the same input is only ever the row above the last row
	a_pair_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |-> out_y != '0)
		else $error("paired result beat on row zero");

endmodule

bind gradient_edge_detector_3x3 ged_checker #(
	.XW($clog2(MAX_WIDTH)),
	.YW($clog2(MAX_HEIGHT))
) u_ged_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(edge_out.valid),
	.out_ready(edge_out.ready),
	.out_x    (edge_out.pixel_x),
	.out_y    (edge_out.pixel_y),
	.out_mag  (edge_out.magnitude),
	.out_last (edge_out.last_of_run)
);
